// ===== sv/smsa_pkg.sv =====
// ----------------------------------------------------------------------------
// smsa_pkg: shared types and constants of the sensor mux sequencer averager
// Field widths, configuration register indexes and reset values, the
// sequencer state encoding and the divider status struct.
// ----------------------------------------------------------------------------
package smsa_pkg;

  localparam int TIME_W     = 32;
  localparam int ADC_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int TDS_DEPTH_DEF = 16;
  localparam int PH_DEPTH_DEF  = 16;

  localparam logic [TIME_W-1:0] TDS_PHASE_RST     = 32'd10000;
  localparam logic [TIME_W-1:0] PH_PHASE_RST      = 32'd10000;
  localparam logic [TIME_W-1:0] TDS_WIN_START_RST = 32'd3000;
  localparam logic [TIME_W-1:0] TDS_WIN_END_RST   = 32'd9000;
  localparam logic [TIME_W-1:0] PH_WIN_START_RST  = 32'd3000;
  localparam logic [TIME_W-1:0] PH_WIN_END_RST    = 32'd9000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TDS_PHASE     = 3'd0,
    CFG_PH_PHASE      = 3'd1,
    CFG_TDS_WIN_START = 3'd2,
    CFG_TDS_WIN_END   = 3'd3,
    CFG_PH_WIN_START  = 3'd4,
    CFG_PH_WIN_END    = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PUSH,
    ST_DIVS,
    ST_DIVW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/smsa_ifs.sv =====
// ----------------------------------------------------------------------------
// smsa_ifs: valid/ready channels of the sensor mux sequencer averager
// Input updates, result items and configuration writes.
// ----------------------------------------------------------------------------
interface smsa_in_if;
  logic                              valid;
  logic                              ready;
  logic [smsa_pkg::TIME_W-1:0]       now_ms;
  logic signed [smsa_pkg::ADC_W-1:0] adc_code;

  modport source(output valid, output now_ms, output adc_code, input ready);
  modport sink(input valid, input now_ms, input adc_code, output ready);
endinterface

interface smsa_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ph_active;
  logic                              switched;
  logic                              sample_taken;
  logic signed [smsa_pkg::ADC_W-1:0] tds_average;
  logic signed [smsa_pkg::ADC_W-1:0] ph_average;

  modport source(output valid, output ph_active, output switched, output sample_taken,
                 output tds_average, output ph_average, input ready);
  modport sink(input valid, input ph_active, input switched, input sample_taken,
               input tds_average, input ph_average, output ready);
endinterface

interface smsa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [smsa_pkg::CFG_IDX_W-1:0]    index;
  logic [smsa_pkg::CFG_DATA_W-1:0]   data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== sv/smsa_ram.sv =====
// ----------------------------------------------------------------------------
// smsa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/smsa_div.sv =====
// ----------------------------------------------------------------------------
// smsa_div: bit-serial signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module smsa_div #(
  parameter int SUM_W  = 21,
  parameter int FILL_W = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [SUM_W-1:0]           dividend,
  input  logic [FILL_W-1:0]                 divisor,
  output smsa_pkg::div_stat_t               stat,
  output logic signed [smsa_pkg::ADC_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [SUM_W-1:0]  q_r;
  logic [FILL_W-1:0] rem_r;
  logic [FILL_W-1:0] den_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [FILL_W:0]   shifted;
  logic [FILL_W:0]   diff;
  logic [SUM_W-1:0]  q_signed;

  assign shifted  = {rem_r, q_r[SUM_W-1]};
  assign diff     = shifted - {1'b0, den_r};
  assign q_signed = neg_r ? (~q_r + 1'b1) : q_r;
  assign quotient = q_signed[smsa_pkg::ADC_W-1:0];
  assign stat     = '{busy: busy_r, done: done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= dividend[SUM_W-1];
        q_r    <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        rem_r  <= '0;
        den_r  <= divisor;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        // keep the difference when no borrow came out
        if (!diff[FILL_W]) begin
          rem_r <= diff[FILL_W-1:0];
          q_r   <= {q_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[FILL_W-1:0];
          q_r   <= {q_r[SUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/sensor_mux_sequencer_averager_top.sv =====
// ----------------------------------------------------------------------------
// sensor_mux_sequencer_averager_top: two-phase sensor sequencer with averages
// Alternates a TDS and a pH phase on millisecond time, keeps a ring buffer
// of samples per phase and reports both truncated averages per update.
// ----------------------------------------------------------------------------
// One update is taken at a time. An update that switches the phase or falls
// outside the read window goes from the evaluate state straight to the done
// state, which it leaves once the output register is free.
// An update that stores a sample reads the oldest entry from its phase's
// ring RAM, updates the running sum and then runs the shared bit-serial
// divider, one quotient bit per cycle over SUM_W = 16 + clog2(max depth + 1)
// bits, max depth being the larger of the two depths: 21 at the default of 16.
// The next update is taken while a finished result still waits in the
// output register. Averages are in ADC code units, rounded toward zero,
// and read 0 until the phase holds a sample.
module sensor_mux_sequencer_averager_top #(
  parameter int TDS_DEPTH = smsa_pkg::TDS_DEPTH_DEF,
  parameter int PH_DEPTH  = smsa_pkg::PH_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  smsa_in_if.sink     in_ch,
  smsa_out_if.source  out_ch,
  smsa_cfg_if.sink    cfg_ch
);

  localparam int MAX_DEPTH = (TDS_DEPTH > PH_DEPTH) ? TDS_DEPTH : PH_DEPTH;
  localparam int FILL_W    = $clog2(MAX_DEPTH + 1);
  localparam int SUM_W     = smsa_pkg::ADC_W + FILL_W;
  localparam int TDS_AW    = (TDS_DEPTH > 1) ? $clog2(TDS_DEPTH) : 1;
  localparam int PH_AW     = (PH_DEPTH > 1) ? $clog2(PH_DEPTH) : 1;
  localparam int TW        = smsa_pkg::TIME_W;
  localparam int AW_ADC    = smsa_pkg::ADC_W;

  // configuration
  logic [TW-1:0] tds_phase_r, ph_phase_r;
  logic [TW-1:0] tds_ws_r, tds_we_r, ph_ws_r, ph_we_r;

  // sequencer and phase state
  smsa_pkg::state_t state_r, state_nxt;
  logic             phase_r;
  logic [TW-1:0]    last_switch_r;
  logic [TW-1:0]    now_r;
  logic [TW-1:0]    elapsed_r;
  logic signed [AW_ADC-1:0] code_r;
  logic             switched_r;
  logic             taken_r;

  // averaging state
  logic [TDS_AW-1:0]        tds_pos_r;
  logic [PH_AW-1:0]         ph_pos_r;
  logic [FILL_W-1:0]        tds_fill_r, ph_fill_r;
  logic signed [SUM_W-1:0]  tds_sum_r, ph_sum_r;
  logic signed [AW_ADC-1:0] tds_avg_r, ph_avg_r;

  // result register
  logic                     out_valid_r;
  logic                     out_ph_r, out_sw_r, out_taken_r;
  logic signed [AW_ADC-1:0] out_tds_r, out_ph_avg_r;

  // control
  logic in_ready;
  logic ram_we;
  logic div_start;
  logic out_free;
  logic out_load;

  // datapath signals
  logic [TW-1:0]            dur, win_s, win_e;
  logic                     sw_hit, win_hit;
  logic [AW_ADC-1:0]        tds_rdata, ph_rdata;
  logic signed [AW_ADC-1:0] old_code;
  logic signed [SUM_W-1:0]  old_ext, code_ext, cur_sum, new_sum;
  logic                     tds_full, ph_full, cur_full;
  logic signed [SUM_W-1:0]  div_dividend;
  logic [FILL_W-1:0]        div_divisor;
  smsa_pkg::div_stat_t      div_stat;
  logic signed [AW_ADC-1:0] div_quot;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ph_active    = out_ph_r;
  assign out_ch.switched     = out_sw_r;
  assign out_ch.sample_taken = out_taken_r;
  assign out_ch.tds_average  = out_tds_r;
  assign out_ch.ph_average   = out_ph_avg_r;

  // phase decision
  assign dur     = phase_r ? ph_phase_r : tds_phase_r;
  assign win_s   = phase_r ? ph_ws_r : tds_ws_r;
  assign win_e   = phase_r ? ph_we_r : tds_we_r;
  assign sw_hit  = elapsed_r >= dur;
  assign win_hit = (elapsed_r >= win_s) && (elapsed_r <= win_e);

  // ring buffer update
  assign tds_full = tds_fill_r == FILL_W'(TDS_DEPTH);
  assign ph_full  = ph_fill_r == FILL_W'(PH_DEPTH);
  assign cur_full = phase_r ? ph_full : tds_full;
  assign old_code = phase_r ? ph_rdata : tds_rdata;
  assign old_ext  = SUM_W'(old_code);
  assign code_ext = SUM_W'(code_r);
  assign cur_sum  = phase_r ? ph_sum_r : tds_sum_r;
  assign new_sum  = cur_sum - (cur_full ? old_ext : '0) + code_ext;

  assign div_dividend = phase_r ? ph_sum_r : tds_sum_r;
  assign div_divisor  = phase_r ? ph_fill_r : tds_fill_r;

  smsa_ram #(.WIDTH(AW_ADC), .DEPTH(TDS_DEPTH)) u_tds_ram (
    .clk   (clk),
    .we    (ram_we && !phase_r),
    .waddr (tds_pos_r),
    .wdata (code_r),
    .raddr (tds_pos_r),
    .rdata (tds_rdata)
  );

  smsa_ram #(.WIDTH(AW_ADC), .DEPTH(PH_DEPTH)) u_ph_ram (
    .clk   (clk),
    .we    (ram_we && phase_r),
    .waddr (ph_pos_r),
    .wdata (code_r),
    .raddr (ph_pos_r),
    .rdata (ph_rdata)
  );

  smsa_div #(.SUM_W(SUM_W), .FILL_W(FILL_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smsa_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = smsa_pkg::ST_EVAL;
      end
      smsa_pkg::ST_EVAL: begin
        if (!sw_hit && win_hit) state_nxt = smsa_pkg::ST_PUSH;
        else state_nxt = smsa_pkg::ST_DONE;
      end
      smsa_pkg::ST_PUSH: state_nxt = smsa_pkg::ST_DIVS;
      smsa_pkg::ST_DIVS: state_nxt = smsa_pkg::ST_DIVW;
      smsa_pkg::ST_DIVW: begin
        if (div_stat.done) state_nxt = smsa_pkg::ST_DONE;
      end
      smsa_pkg::ST_DONE: begin
        if (out_free) state_nxt = smsa_pkg::ST_IDLE;
      end
      default: state_nxt = smsa_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      smsa_pkg::ST_IDLE: in_ready  = 1'b1;
      smsa_pkg::ST_PUSH: ram_we    = 1'b1;
      smsa_pkg::ST_DIVS: div_start = 1'b1;
      smsa_pkg::ST_DONE: out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= smsa_pkg::ST_IDLE;
      tds_phase_r   <= smsa_pkg::TDS_PHASE_RST;
      ph_phase_r    <= smsa_pkg::PH_PHASE_RST;
      tds_ws_r      <= smsa_pkg::TDS_WIN_START_RST;
      tds_we_r      <= smsa_pkg::TDS_WIN_END_RST;
      ph_ws_r       <= smsa_pkg::PH_WIN_START_RST;
      ph_we_r       <= smsa_pkg::PH_WIN_END_RST;
      phase_r       <= 1'b0;
      last_switch_r <= '0;
      tds_pos_r     <= '0;
      ph_pos_r      <= '0;
      tds_fill_r    <= '0;
      ph_fill_r     <= '0;
      tds_sum_r     <= '0;
      ph_sum_r      <= '0;
      tds_avg_r     <= '0;
      ph_avg_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          smsa_pkg::CFG_TDS_PHASE:     tds_phase_r <= cfg_ch.data;
          smsa_pkg::CFG_PH_PHASE:      ph_phase_r  <= cfg_ch.data;
          smsa_pkg::CFG_TDS_WIN_START: tds_ws_r    <= cfg_ch.data;
          smsa_pkg::CFG_TDS_WIN_END:   tds_we_r    <= cfg_ch.data;
          smsa_pkg::CFG_PH_WIN_START:  ph_ws_r     <= cfg_ch.data;
          smsa_pkg::CFG_PH_WIN_END:    ph_we_r     <= cfg_ch.data;
          default: ;
        endcase
      end

      if (in_ready && in_ch.valid) begin
        now_r     <= in_ch.now_ms;
        code_r    <= in_ch.adc_code;
        elapsed_r <= in_ch.now_ms - last_switch_r;
      end

      if (state_r == smsa_pkg::ST_EVAL) begin
        switched_r <= sw_hit;
        taken_r    <= !sw_hit && win_hit;
        if (sw_hit) begin
          phase_r       <= !phase_r;
          last_switch_r <= now_r;
        end
      end

      // replace the oldest entry once the buffer is full
      if (state_r == smsa_pkg::ST_PUSH) begin
        if (phase_r) begin
          ph_sum_r <= new_sum;
          ph_pos_r <= (ph_pos_r == PH_AW'(PH_DEPTH - 1)) ? '0 : ph_pos_r + 1'b1;
          if (!ph_full) ph_fill_r <= ph_fill_r + 1'b1;
        end else begin
          tds_sum_r <= new_sum;
          tds_pos_r <= (tds_pos_r == TDS_AW'(TDS_DEPTH - 1)) ? '0 : tds_pos_r + 1'b1;
          if (!tds_full) tds_fill_r <= tds_fill_r + 1'b1;
        end
      end

      if (state_r == smsa_pkg::ST_DIVW && div_stat.done) begin
        if (phase_r) ph_avg_r <= div_quot;
        else tds_avg_r <= div_quot;
      end

      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_ph_r     <= phase_r;
        out_sw_r     <= switched_r;
        out_taken_r  <= taken_r;
        out_tds_r    <= tds_avg_r;
        out_ph_avg_r <= ph_avg_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_sw_xor_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.switched && out_ch.sample_taken))
    else $error("result reports both a phase switch and a stored sample");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (tds_fill_r <= FILL_W'(TDS_DEPTH)) && (ph_fill_r <= FILL_W'(PH_DEPTH)))
    else $error("buffer fill count above depth");

  a_phase_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != $past(phase_r)) |-> ($past(state_r) == smsa_pkg::ST_EVAL))
    else $error("phase toggled outside evaluation");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == smsa_pkg::ST_DIVW))
    else $error("divider finished while sequencer not waiting");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == smsa_pkg::ST_EVAL))
    else $error("accepted update not evaluated next cycle");

endmodule
